### rtl/core/udsrbi_pkg.sv
// ----------------------------------------------------------------------------
// udsrbi_pkg
// Shared types and constants of the read-by-identifier responder.
// ----------------------------------------------------------------------------
package udsrbi_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CAN_ID_IDENT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_IDENT   = 8'd1;

    localparam logic [15:0] CAN_ID_IDENT_RST = 16'h0123;
    localparam logic [15:0] TEMP_IDENT_RST   = 16'h0124;

    localparam logic [15:0] REQ_LEN_OK = 16'd3;

    // response bytes
    localparam logic [7:0] RSP_NEG      = 8'h7F;
    localparam logic [7:0] RSP_POS      = 8'h62;
    localparam logic [7:0] SID_RDBI     = 8'h22;
    localparam logic [7:0] NRC_BAD_LEN  = 8'h13;
    localparam logic [7:0] NRC_OUT_RNG  = 8'h31;

    // temperature conversion
    localparam logic [11:0] VREF_MV      = 12'd3300;
    localparam logic [12:0] ADC_FULL     = 13'd4095;
    localparam logic [12:0] V25_MV       = 13'd760;
    localparam logic [14:0] RECIP_DIV5   = 15'd13108;  // ceil(2^16 / 5)
    localparam logic [10:0] T_OFFSET     = 11'd25;
    localparam logic [10:0] T_POS_SPAN   = 11'd100;    // 125 - 25
    localparam logic [7:0]  T_MAX        = 8'd125;
    localparam logic [7:0]  T_ZERO       = 8'd0;
    localparam logic [7:0]  T_NO_SAMPLE  = 8'd28;

    // response kind decided at decode
    typedef enum logic [1:0] {
        KIND_BAD_LEN = 2'd0,
        KIND_UNKNOWN = 2'd1,
        KIND_CAN     = 2'd2,
        KIND_TEMP    = 2'd3
    } t_kind;

    // fields carried down the pipeline next to the temperature datapath
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  id_hi;
        logic [7:0]  id_lo;
        logic [15:0] can;
        logic        raw_zero;
    } t_item;

    localparam int unsigned RSP_MAX = 5;
    localparam int unsigned RSP_IDX_W = $clog2(RSP_MAX);

    typedef struct packed {
        logic [RSP_MAX-1:0][7:0] bytes;
        logic [RSP_IDX_W-1:0]    last_idx;
        logic                    positive;
    } t_resp;

endpackage

### rtl/core/uds_read_by_identifier_responder.sv
// ----------------------------------------------------------------------------
// Order: an accepted request passes the front pipeline stages and then the serializer,
// which drives the first response byte; the other bytes follow on consecutive cycles.
// Flow: the single byte-wide output serializer takes the next response on the last
// byte of the current one; the 4-stage front pipeline buffers behind it.
// Reset: synchronous active-low; clears all valid bits, identifier registers go to
// 0x0123 (CAN ID) and 0x0124 (temperature). The receiver cannot stall.
// ----------------------------------------------------------------------------
// uds_read_by_identifier_responder
// Read-data-by-identifier (service 0x22) responder, top level.
// ----------------------------------------------------------------------------
module uds_read_by_identifier_responder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [15:0]                     i_request_length,
    input  logic [7:0]                      i_identifier_high,
    input  logic [7:0]                      i_identifier_low,
    input  logic [15:0]                     i_current_can_id,
    input  logic [11:0]                     i_temperature_raw,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [udsrbi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    // response bytes
    output logic                            o_valid,
    output logic [7:0]                      o_response_byte,
    output logic                            o_last_byte,
    output logic                            o_positive
);
    import udsrbi_pkg::*;

    // identifier registers; the user must write them only while idle, the block does not enforce it
    logic [15:0] r_can_ident;
    logic [15:0] r_temp_ident;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_can_ident  <= CAN_ID_IDENT_RST;
            r_temp_ident <= TEMP_IDENT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CAN_ID_IDENT) begin
                r_can_ident <= i_cfg_data;
            end
            if (i_cfg_index == CFG_TEMP_IDENT) begin
                r_temp_ident <= i_cfg_data;
            end
        end
    end

    // Pipeline control: all four stages move together. They hold only when
    // the last stage has a response the serializer cannot take yet, so no
    // item is dropped or duplicated. busy mirrors that hold.
    logic  pipe_en;
    logic  accept;
    logic  s1_valid;
    t_item s1_item;
    logic [23:0] s1_prod;
    logic  s4_valid;
    t_resp s4_resp;
    logic  ser_ready;

    assign pipe_en = !s4_valid || ser_ready;
    assign busy    = !pipe_en;
    assign accept  = start && pipe_en;

    // stage 1: decode, raw * 3300
    udsrbi_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (pipe_en),
        .i_accept          (accept),
        .i_request_length  (i_request_length),
        .i_identifier_high (i_identifier_high),
        .i_identifier_low  (i_identifier_low),
        .i_current_can_id  (i_current_can_id),
        .i_temperature_raw (i_temperature_raw),
        .i_can_ident       (r_can_ident),
        .i_temp_ident      (r_temp_ident),
        .o_valid           (s1_valid),
        .o_item            (s1_item),
        .o_prod            (s1_prod)
    );

    // stages 2..4: temperature math and response assembly
    udsrbi_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (s1_valid),
        .i_item  (s1_item),
        .i_prod  (s1_prod),
        .o_valid (s4_valid),
        .o_resp  (s4_resp)
    );

    // byte serializer; takes the next response on the last byte of the current one
    udsrbi_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s4_valid),
        .i_resp          (s4_resp),
        .o_ready         (ser_ready),
        .o_valid         (o_valid),
        .o_response_byte (o_response_byte),
        .o_last_byte     (o_last_byte),
        .o_positive      (o_positive)
    );

endmodule

### rtl/core/udsrbi_front.sv
// ----------------------------------------------------------------------------
// udsrbi_front
// Stage 1: request decode and raw sample scaling product.
// ----------------------------------------------------------------------------
module udsrbi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_accept,
    input  logic [15:0]          i_request_length,
    input  logic [7:0]           i_identifier_high,
    input  logic [7:0]           i_identifier_low,
    input  logic [15:0]          i_current_can_id,
    input  logic [11:0]          i_temperature_raw,
    input  logic [15:0]          i_can_ident,
    input  logic [15:0]          i_temp_ident,
    output logic                 o_valid,
    output udsrbi_pkg::t_item    o_item,
    output logic [23:0]          o_prod
);
    import udsrbi_pkg::*;

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [23:0] r_prod;
    logic [15:0] id;

    assign id = {i_identifier_high, i_identifier_low};

    always_comb begin
        n_item.id_hi    = i_identifier_high;
        n_item.id_lo    = i_identifier_low;
        n_item.can      = i_current_can_id;
        n_item.raw_zero = (i_temperature_raw == 12'd0);
        if (i_request_length != REQ_LEN_OK) begin
            n_item.kind = KIND_BAD_LEN;
        end else if (id == i_can_ident) begin
            n_item.kind = KIND_CAN;   // wins when both identifiers match
        end else if (id == i_temp_ident) begin
            n_item.kind = KIND_TEMP;
        end else begin
            n_item.kind = KIND_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_prod <= {12'd0, i_temperature_raw} * {12'd0, VREF_MV};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_prod  = r_prod;

endmodule

### rtl/core/udsrbi_temp.sv
// ----------------------------------------------------------------------------
// udsrbi_temp
// Stages 2..4: millivolt division, Celsius scaling, clamp, response build.
// ----------------------------------------------------------------------------
module udsrbi_temp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  udsrbi_pkg::t_item  i_item,
    input  logic [23:0]        i_prod,
    output logic               o_valid,
    output udsrbi_pkg::t_resp  o_resp
);
    import udsrbi_pkg::*;

    // stage 2: mv = prod / 4095 as prod>>12 plus one correction step
    logic        r2_valid;
    t_item       r2_item;
    logic [11:0] r2_mv;
    logic [11:0] q0;
    logic [12:0] rem;

    assign q0  = i_prod[23:12];
    assign rem = {1'b0, i_prod[11:0]} + {1'b0, q0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_item <= i_item;
            r2_mv   <= (rem >= ADC_FULL) ? q0 + 12'd1 : q0;
        end
    end

    // stage 3: |2*(mv-760)| times reciprocal of 5
    logic        r3_valid;
    t_item       r3_item;
    logic        r3_neg;
    logic [27:0] r3_prod;
    logic [13:0] dbl;
    logic        neg;
    logic [12:0] mag;

    always_comb begin
        dbl = {1'b0, r2_mv, 1'b0} - {V25_MV, 1'b0};
        neg = dbl[13];
        mag = neg ? 13'(-dbl) : dbl[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_item <= r2_item;
            r3_neg  <= neg;
            r3_prod <= {15'd0, mag} * {13'd0, RECIP_DIV5};
        end
    end

    // stage 4: offset, clamp, build response
    logic        r4_valid;
    t_resp       r4_resp;
    t_resp       n_resp;
    logic [10:0] quo;
    logic [7:0]  temp_c;

    assign quo = r3_prod[26:16];

    always_comb begin
        if (r3_item.raw_zero) begin
            temp_c = T_NO_SAMPLE;
        end else if (r3_neg) begin
            temp_c = (quo > T_OFFSET) ? T_ZERO : 8'(T_OFFSET - quo);
        end else begin
            temp_c = (quo > T_POS_SPAN) ? T_MAX : 8'(T_OFFSET + quo);
        end
    end

    always_comb begin
        n_resp.bytes[0] = RSP_NEG;
        n_resp.bytes[1] = SID_RDBI;
        n_resp.bytes[2] = NRC_OUT_RNG;
        n_resp.bytes[3] = 8'd0;
        n_resp.bytes[4] = 8'd0;
        n_resp.last_idx = RSP_IDX_W'(2);
        n_resp.positive = 1'b0;
        case (r3_item.kind)
            KIND_BAD_LEN: begin
                n_resp.bytes[2] = NRC_BAD_LEN;
            end
            KIND_CAN: begin
                n_resp.bytes[0] = RSP_POS;
                n_resp.bytes[1] = r3_item.id_hi;
                n_resp.bytes[2] = r3_item.id_lo;
                n_resp.bytes[3] = r3_item.can[15:8];
                n_resp.bytes[4] = r3_item.can[7:0];
                n_resp.last_idx = RSP_IDX_W'(4);
                n_resp.positive = 1'b1;
            end
            KIND_TEMP: begin
                n_resp.bytes[0] = RSP_POS;
                n_resp.bytes[1] = r3_item.id_hi;
                n_resp.bytes[2] = r3_item.id_lo;
                n_resp.bytes[3] = temp_c;
                n_resp.last_idx = RSP_IDX_W'(3);
                n_resp.positive = 1'b1;
            end
            default: begin
                n_resp.bytes[2] = NRC_OUT_RNG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_resp <= n_resp;
        end
    end

    assign o_valid = r4_valid;
    assign o_resp  = r4_resp;

endmodule

### rtl/core/udsrbi_ser.sv
// ----------------------------------------------------------------------------
// udsrbi_ser
// Byte serializer: plays one response out, one byte per cycle.
// ----------------------------------------------------------------------------
module udsrbi_ser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  udsrbi_pkg::t_resp  i_resp,
    output logic               o_ready,
    output logic               o_valid,
    output logic [7:0]         o_response_byte,
    output logic               o_last_byte,
    output logic               o_positive
);
    import udsrbi_pkg::*;

    logic                 r_active;
    t_resp                r_resp;
    logic [RSP_IDX_W-1:0] r_idx;
    logic                 last;
    logic                 load;

    assign last    = (r_idx == r_resp.last_idx);
    assign o_ready = !r_active || last;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (load) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (r_active) begin
            r_active <= !last;
            r_idx    <= r_idx + RSP_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_resp <= i_resp;
        end
    end

    assign o_valid         = r_active;
    assign o_response_byte = r_resp.bytes[r_idx];
    assign o_last_byte     = last;
    assign o_positive      = r_resp.positive;

endmodule

### test/uds_read_by_identifier_responder_tb.sv
// ----------------------------------------------------------------------------
// uds_read_by_identifier_responder_tb
// Self-checking bench for the read-by-identifier responder: requests go in
// through the start/busy port, directed and in random bursts, identifier registers are
// rewritten between phases, and every response byte is compared against a
// predicted byte stream held by a small tracker class.
// ----------------------------------------------------------------------------
module uds_read_by_identifier_responder_tb;

    import udsrbi_pkg::*;

    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 12;  // lets the pipe settle after the last byte
    localparam int unsigned PHASE_ITEMS = 36;

    // one predicted response byte
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       positive;
    } t_rsp_byte;

    // ------------------------------------------------------------------------
    // Tracker: own copy of the two identifier registers, a predictor that
    // turns each accepted request into its response bytes, and the check.
    // ------------------------------------------------------------------------
    class response_tracker;
        logic [15:0] can_ident;
        logic [15:0] temp_ident;
        t_rsp_byte   pending_bytes[$];
        int unsigned errors;
        int unsigned requests;
        int unsigned bytes_seen;
        int unsigned kind_count[4];

        function new();
            can_ident  = CAN_ID_IDENT_RST;
            temp_ident = TEMP_IDENT_RST;
            errors     = 0;
            requests   = 0;
            bytes_seen = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_CAN_ID_IDENT: can_ident  = val;
                CFG_TEMP_IDENT:   temp_ident = val;
                default: ;
            endcase
        endfunction

        // raw ADC count -> degrees C, division truncating toward zero
        function logic [7:0] celsius_of_raw(logic [11:0] raw);
            int mv;
            int t;
            mv = (int'(raw) * int'(VREF_MV)) / int'(ADC_FULL);
            t  = ((mv - int'(V25_MV)) * 10) / 25 + int'(T_OFFSET);
            if (t < 0)
                t = 0;
            else if (t > int'(T_MAX))
                t = int'(T_MAX);
            if (raw == 12'd0)
                t = int'(T_NO_SAMPLE);
            return t[7:0];
        endfunction

        function void push_bytes(logic [7:0] b[5], int n, logic pos);
            t_rsp_byte e;
            for (int k = 0; k < n; k++) begin
                e.data     = b[k];
                e.last     = (k == n - 1);
                e.positive = pos;
                pending_bytes.push_back(e);
            end
        endfunction

        // note an accepted request and queue the bytes it must produce
        function void note_request(logic [15:0] len, logic [7:0] id_hi, logic [7:0] id_lo,
                                   logic [15:0] can, logic [11:0] raw);
            logic [7:0] b[5];
            t_kind      kind;
            if (len != REQ_LEN_OK)
                kind = KIND_BAD_LEN;
            else if ({id_hi, id_lo} == can_ident)   // CAN answer wins on equal regs
                kind = KIND_CAN;
            else if ({id_hi, id_lo} == temp_ident)
                kind = KIND_TEMP;
            else
                kind = KIND_UNKNOWN;
            requests++;
            kind_count[kind]++;
            foreach (b[k]) b[k] = 8'h00;
            case (kind)
                KIND_BAD_LEN: begin
                    b[0] = RSP_NEG; b[1] = SID_RDBI; b[2] = NRC_BAD_LEN;
                    push_bytes(b, 3, 1'b0);
                end
                KIND_UNKNOWN: begin
                    b[0] = RSP_NEG; b[1] = SID_RDBI; b[2] = NRC_OUT_RNG;
                    push_bytes(b, 3, 1'b0);
                end
                KIND_CAN: begin
                    b[0] = RSP_POS; b[1] = can_ident[15:8]; b[2] = can_ident[7:0];
                    b[3] = can[15:8]; b[4] = can[7:0];
                    push_bytes(b, 5, 1'b1);
                end
                default: begin
                    b[0] = RSP_POS; b[1] = temp_ident[15:8]; b[2] = temp_ident[7:0];
                    b[3] = celsius_of_raw(raw);
                    push_bytes(b, 4, 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_byte(logic [7:0] data, logic last, logic pos);
            t_rsp_byte e;
            bytes_seen++;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last=%b pos=%b", data, last, pos));
            end else begin
                e = pending_bytes.pop_front();
                if (data !== e.data)
                    report($sformatf("response_byte %02h, want %02h", data, e.data));
                if (last !== e.last)
                    report($sformatf("last_byte %b, want %b (byte %02h)", last, e.last, e.data));
                if (pos !== e.positive)
                    report($sformatf("positive %b, want %b (byte %02h)", pos, e.positive,
                                     e.data));
            end
        endtask

        function int unsigned pending();
            return pending_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [15:0]          i_request_length;
    logic [7:0]           i_identifier_high;
    logic [7:0]           i_identifier_low;
    logic [15:0]          i_current_can_id;
    logic [11:0]          i_temperature_raw;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 o_valid;
    logic [7:0]           o_response_byte;
    logic                 o_last_byte;
    logic                 o_positive;

    uds_read_by_identifier_responder DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_request_length  (i_request_length),
        .i_identifier_high (i_identifier_high),
        .i_identifier_low  (i_identifier_low),
        .i_current_can_id  (i_current_can_id),
        .i_temperature_raw (i_temperature_raw),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_response_byte   (o_response_byte),
        .o_last_byte       (o_last_byte),
        .o_positive        (o_positive)
    );

    response_tracker tracker;
    int unsigned     cycles;
    int unsigned     settings_used;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog: fails the run if it goes on past CYCLE_LIMIT
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles,
                     tracker.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // response monitor: the receiver never stalls, every strobe is one byte.
    // An X strobe counts as a byte so it gets flagged rather than hidden.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0)
            tracker.check_byte(o_response_byte, o_last_byte, o_positive);
    end

    // ------------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes read on the rising
    // ------------------------------------------------------------------------

    // present one item and hold it until the block takes it (busy low at the edge);
    // start is left high so a following item can go out back to back
    task automatic send_request(input logic [15:0] len, input logic [7:0] id_hi,
                                input logic [7:0] id_lo, input logic [15:0] can,
                                input logic [11:0] raw);
        @(negedge i_clk);
        start             = 1'b1;
        i_request_length  = len;
        i_identifier_high = id_hi;
        i_identifier_low  = id_lo;
        i_current_can_id  = can;
        i_temperature_raw = raw;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.note_request(len, id_hi, id_lo, can, raw);
    endtask

    // sender gap with start low; n sets its length
    task automatic hold_off(input int unsigned n);
        if (n > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // stop sending, let every due byte come out, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_identifiers(input logic [15:0] can_val, input logic [15:0] temp_val);
        wait_idle();
        write_reg(CFG_CAN_ID_IDENT, can_val);
        write_reg(CFG_TEMP_IDENT, temp_val);
        settings_used++;
    endtask

    // Random request. Most are well formed (length 3, a configured identifier)
    // so the positive paths get real traffic; the rest is noise.
    task automatic send_random();
        logic [15:0] len;
        logic [15:0] ident;
        logic [11:0] raw;
        len = REQ_LEN_OK;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ident = tracker.can_ident;
            4, 5, 6:    ident = tracker.temp_ident;
            7:          ident = 16'($urandom_range(0, 65535));
            8: begin
                len   = 16'($urandom_range(0, 65535));
                ident = ($urandom_range(0, 1) != 0) ? tracker.can_ident : tracker.temp_ident;
            end
            default: begin
                len   = 16'($urandom_range(0, 6));
                ident = 16'($urandom_range(0, 65535));
            end
        endcase
        case ($urandom_range(0, 9))
            0:       raw = 12'd0;
            1:       raw = 12'($urandom_range(1, 960));      // low end, down to the 0 C clamp
            2:       raw = 12'($urandom_range(1200, 1300));  // around the 125 C clamp
            3:       raw = 12'hFFF;
            default: raw = 12'($urandom_range(0, 4095));
        endcase
        send_request(len, ident[15:8], ident[7:0], 16'($urandom_range(0, 65535)), raw);
    endtask

    // bursts of back-to-back items separated by random gaps; some gaps are zero
    task automatic run_random(input int unsigned n);
        int unsigned left;
        int unsigned burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst) send_random();
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 9));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        tracker           = new();
        settings_used     = 1;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_request_length  = '0;
        i_identifier_high = '0;
        i_identifier_low  = '0;
        i_current_can_id  = '0;
        i_temperature_raw = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset identifiers 0x0123 / 0x0124.
        // CAN identifier answers, extreme CAN IDs
        send_request(REQ_LEN_OK, 8'h01, 8'h23, 16'h0000, 12'h000);
        send_request(REQ_LEN_OK, 8'h01, 8'h23, 16'hFFFF, 12'hFFF);
        // temperature: no sample, clamp low, truncation toward zero around 25 C,
        // mid scale, clamp high
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd0);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd1);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd900);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd941);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd942);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd1253);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd2048);
        send_request(REQ_LEN_OK, 8'h01, 8'h24, 16'h1234, 12'd4095);
        // wrong length, even with a known identifier
        send_request(16'd0,      8'h01, 8'h23, 16'hAAAA, 12'h555);
        send_request(16'd2,      8'h01, 8'h24, 16'h5555, 12'hAAA);
        send_request(16'd4,      8'h01, 8'h23, 16'hAAAA, 12'h555);
        send_request(16'hFFFF,   8'hFF, 8'hFF, 16'hFFFF, 12'hFFF);
        hold_off(3);
        // unknown identifiers
        send_request(REQ_LEN_OK, 8'hFF, 8'hFF, 16'h0F0F, 12'h0F0);
        send_request(REQ_LEN_OK, 8'h00, 8'h00, 16'hF0F0, 12'hF0F);
        send_request(REQ_LEN_OK, 8'h01, 8'h25, 16'h0001, 12'h001);
        send_request(REQ_LEN_OK, 8'h02, 8'h23, 16'h8000, 12'h800);
        run_random(PHASE_ITEMS);

        // identifier extremes, swapped, then equal (CAN answer must win)
        set_identifiers(16'h0000, 16'hFFFF);
        send_request(REQ_LEN_OK, 8'h00, 8'h00, 16'hC3C3, 12'h3C3);
        send_request(REQ_LEN_OK, 8'hFF, 8'hFF, 16'hC3C3, 12'hFFF);
        run_random(PHASE_ITEMS);

        set_identifiers(16'hFFFF, 16'h0000);
        run_random(PHASE_ITEMS);

        set_identifiers(16'h5AA5, 16'h5AA5);
        send_request(REQ_LEN_OK, 8'h5A, 8'hA5, 16'h1357, 12'd2000);
        run_random(PHASE_ITEMS);

        set_identifiers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);

        set_identifiers(CAN_ID_IDENT_RST, TEMP_IDENT_RST);
        run_random(PHASE_ITEMS / 2);

        wait_idle();

        $display("covered %0d requests over %0d identifier settings: CAN %0d, temperature %0d,",
                 tracker.requests, settings_used, tracker.kind_count[KIND_CAN],
                 tracker.kind_count[KIND_TEMP]);
        $display("bad length %0d, unknown identifier %0d; %0d response bytes checked",
                 tracker.kind_count[KIND_BAD_LEN], tracker.kind_count[KIND_UNKNOWN],
                 tracker.bytes_seen);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d bytes never seen", tracker.errors, tracker.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### uds_read_by_identifier_responder.f
rtl/core/udsrbi_pkg.sv
rtl/core/udsrbi_front.sv
rtl/core/udsrbi_temp.sv
rtl/core/udsrbi_ser.sv
rtl/core/uds_read_by_identifier_responder.sv
test/uds_read_by_identifier_responder_tb.sv
